@@ rtl/apt_pkg.sv @@
// Shared types, constants and codes for the aging peer table.
`timescale 1ns / 1ps

package apt_pkg;

  localparam int SLOTS   = 8;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int TICK_W  = 32;
  localparam int HOST_W  = 32;
  localparam int PORT_W  = 16;
  localparam int VER_W   = 16;
  localparam int LIMIT_W = 16;
  localparam int CFG_W   = 16;

  localparam int SLOT_OUT_W  = 3;
  localparam int COUNT_OUT_W = 4;

  // Input operation codes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_BEACON = 1'b1;

  // Configuration register indexes
  localparam logic CFG_STALE_LIMIT      = 1'b0;
  localparam logic CFG_EXPECTED_VERSION = 1'b1;

  localparam logic [LIMIT_W-1:0] STALE_LIMIT_RST = LIMIT_W'(360);
  localparam logic [VER_W-1:0]   EXP_VERSION_RST = VER_W'(1);

  typedef enum logic [1:0] {
    ACT_REFRESH = 2'd0,
    ACT_FILL    = 2'd1,
    ACT_EVICT   = 2'd2,
    ACT_TICK    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic              operation;
    logic [HOST_W-1:0] host_addr;
    logic [PORT_W-1:0] peer_port;
    logic [VER_W-1:0]  peer_version;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0]  slot_index;
    logic [1:0]             action;
    logic                   is_compatible;
    logic [COUNT_OUT_W-1:0] expired_count;
    logic [COUNT_OUT_W-1:0] live_count;
  } out_item_t;

  // Item broadcast to every cell during a scan
  typedef struct packed {
    logic               op;
    logic [HOST_W-1:0]  host;
    logic [PORT_W-1:0]  port;
    logic [TICK_W-1:0]  tick;
    logic [LIMIT_W-1:0] stale_limit;
  } scan_cmd_t;

  // Running scan result handed from cell to cell
  typedef struct packed {
    logic              match_hit;
    logic [IDX_W-1:0]  match_idx;
    logic              free_hit;
    logic [IDX_W-1:0]  free_idx;
    logic              old_hit;
    logic [IDX_W-1:0]  old_idx;
    logic [TICK_W-1:0] old_seen;
    logic [CNT_W-1:0]  live;
    logic [CNT_W-1:0]  expired;
  } scan_acc_t;

  localparam scan_acc_t ACC_INIT = '0;

  // Slot write broadcast at the end of a beacon
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [HOST_W-1:0] host;
    logic [PORT_W-1:0] port;
    logic              compat;
    logic [TICK_W-1:0] seen;
  } slot_wr_t;

endpackage

@@ rtl/aging_peer_table_unit.sv @@
// Top level of the aging peer table: control, configuration and the row of slot cells.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_stall_o / in_data_i): one transaction is either a
//   time tick or a received beacon carrying host address, port and version.
//   Output channel (out_valid_o / out_stall_i / out_data_o): exactly one result
//   transaction per input: chosen slot, action, compatibility, expired and live counts.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (stale limit,
//   expected version); write only while no transaction is in flight.
// Timing
//   An accepted transaction launches a token down the row of SLOTS cells, one cell
//   per cycle; each cell folds its slot into the running match / free / oldest /
//   count record. The last cell's record decides the result and the slot write.
//   One transaction is in flight at a time and the input reopens in the cycle after
//   the result is committed, so throughput is set by the token walking the chain.
// Reset
//   All slots invalid, tick counter zero, stale limit 360, expected version 1.
// Backpressure
//   The result sits in an output register; the next input is taken meanwhile. If a
//   new result is ready while the old one is still stalled, the block holds in its
//   finish step and commits only once the output register frees.

module aging_peer_table_unit import apt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  ctrl_state_e state_q, state_d;

  logic               start_q;
  in_item_t           item_q;
  logic [TICK_W-1:0]  tick_q;
  logic [LIMIT_W-1:0] stale_q;
  logic [VER_W-1:0]   ver_q;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic      in_accept;
  logic      out_free;
  logic      commit;
  scan_cmd_t cmd;
  slot_wr_t  wr;

  logic      tok [SLOTS+1];
  scan_acc_t acc [SLOTS+1];
  scan_acc_t fin;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Broadcast the held item to every cell
  assign cmd.op          = item_q.operation;
  assign cmd.host        = item_q.host_addr;
  assign cmd.port        = item_q.peer_port;
  assign cmd.tick        = tick_q;
  assign cmd.stale_limit = stale_q;

  assign tok[0] = start_q;
  assign acc[0] = ACC_INIT;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    apt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .cmd_i      (cmd),
      .tok_i      (tok[g]),
      .acc_i      (acc[g]),
      .wr_i       (wr),
      .tok_o      (tok[g+1]),
      .acc_o      (acc[g+1])
    );
  end

  assign fin = acc[SLOTS];

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok[SLOTS]) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the controller
  always_comb begin
    in_stall_o = 1'b1;
    commit     = 1'b0;
    case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_SCAN:   in_stall_o = 1'b1;
      ST_FINISH: commit     = out_free;
      default:   in_stall_o = 1'b1;
    endcase
  end

  // Decide the result from the finished scan record
  always_comb begin
    logic [IDX_W-1:0] idx;
    action_e          act;
    logic             compat;
    logic [CNT_W-1:0] live;
    idx    = fin.old_idx;
    act    = ACT_EVICT;
    compat = (item_q.peer_version == ver_q);
    live   = fin.live;
    if (fin.match_hit) begin
      idx = fin.match_idx;
      act = ACT_REFRESH;
    end else if (fin.free_hit) begin
      idx  = fin.free_idx;
      act  = ACT_FILL;
      live = fin.live + CNT_W'(1);
    end

    wr.en     = commit && (item_q.operation == OP_BEACON);
    wr.idx    = idx;
    wr.host   = item_q.host_addr;
    wr.port   = item_q.peer_port;
    wr.compat = compat;
    wr.seen   = tick_q;

    if (item_q.operation == OP_BEACON) begin
      out_d.slot_index    = SLOT_OUT_W'(idx);
      out_d.action        = act;
      out_d.is_compatible = compat;
      out_d.expired_count = '0;
      out_d.live_count    = COUNT_OUT_W'(live);
    end else begin
      out_d.slot_index    = '0;
      out_d.action        = ACT_TICK;
      out_d.is_compatible = 1'b0;
      out_d.expired_count = COUNT_OUT_W'(fin.expired);
      out_d.live_count    = COUNT_OUT_W'(fin.live);
    end

    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      tick_q      <= '0;
      stale_q     <= STALE_LIMIT_RST;
      ver_q       <= EXP_VERSION_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= in_accept;
      out_valid_q <= out_valid_d;
      // advance time before the expiry sweep sees it
      if (in_accept && (in_data_i.operation == OP_TICK)) begin
        tick_q <= tick_q + TICK_W'(1);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STALE_LIMIT:      stale_q <= LIMIT_W'(cfg_wdata_i);
          CFG_EXPECTED_VERSION: ver_q   <= VER_W'(cfg_wdata_i);
          default:              stale_q <= stale_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/apt_cell.sv @@
// One table slot: stored entry plus one step of the scan chain.
`timescale 1ns / 1ps

module apt_cell import apt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  scan_cmd_t        cmd_i,
  input  logic             tok_i,
  input  scan_acc_t        acc_i,
  input  slot_wr_t         wr_i,
  output logic             tok_o,
  output scan_acc_t        acc_o
);

  logic              valid_q, valid_d;
  logic [HOST_W-1:0] host_q;
  logic [PORT_W-1:0] port_q;
  logic              compat_q;
  logic [TICK_W-1:0] seen_q;
  logic              tok_q;
  scan_acc_t         acc_q, acc_d;

  logic              wr_hit;
  logic [TICK_W-1:0] age;
  logic              expire;
  logic              match;

  assign wr_hit = wr_i.en && (wr_i.idx == cell_idx_i);
  assign age    = cmd_i.tick - seen_q;
  assign expire = valid_q && (age > {{(TICK_W-LIMIT_W){1'b0}}, cmd_i.stale_limit});
  assign match  = valid_q && (host_q == cmd_i.host) && (port_q == cmd_i.port);

  always_comb begin
    valid_d = valid_q;
    acc_d   = acc_i;
    if (tok_i) begin
      if (cmd_i.op == OP_TICK) begin
        // expire on the way past, count what stays
        valid_d = valid_q && !expire;
        if (expire) begin
          acc_d.expired = acc_i.expired + CNT_W'(1);
        end
        if (valid_d) begin
          acc_d.live = acc_i.live + CNT_W'(1);
        end
      end else begin
        if (valid_q) begin
          acc_d.live = acc_i.live + CNT_W'(1);
        end
        if (match && !acc_i.match_hit) begin
          acc_d.match_hit = 1'b1;
          acc_d.match_idx = cell_idx_i;
        end
        if (!valid_q && !acc_i.free_hit) begin
          acc_d.free_hit = 1'b1;
          acc_d.free_idx = cell_idx_i;
        end
        // strict compare keeps the lowest slot on a tie
        if (valid_q && (!acc_i.old_hit || (seen_q < acc_i.old_seen))) begin
          acc_d.old_hit  = 1'b1;
          acc_d.old_idx  = cell_idx_i;
          acc_d.old_seen = seen_q;
        end
      end
    end
    if (wr_hit) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i) begin
      acc_q <= acc_d;
    end
    if (wr_hit) begin
      host_q   <= wr_i.host;
      port_q   <= wr_i.port;
      compat_q <= wr_i.compat;
      seen_q   <= wr_i.seen;
    end
  end

  assign tok_o = tok_q;
  // compatibility bit is kept with the entry for the stored peer record
  assign acc_o = compat_q ? acc_q : acc_q;

endmodule

@@ rtl/apt_checker.sv @@
// Port-level checks for the aging peer table, bound to the top level.
`timescale 1ns / 1ps

module apt_checker import apt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input out_item_t        out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // one transaction at a time: an accepted input makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a transaction is in flight");

  // tick results carry no slot and no compatibility
  a_tick_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.action == ACT_TICK) |->
      (out_data_o.slot_index == '0) && !out_data_o.is_compatible)
    else $error("tick result with slot or compatibility set");

  // beacons never expire entries, and counts stay within the table
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.action == ACT_TICK) || (out_data_o.expired_count == '0))
      && (out_data_o.live_count <= COUNT_OUT_W'(SLOTS)))
    else $error("bad counts in result");

endmodule

bind aging_peer_table_unit apt_checker u_apt_checker (.*);
